>>> hdl/bgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared widths, register indexes and helpers for the bias/gain curve mapper.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int QUO_BITS    = FRAC_BITS + 1;
  localparam int DIV_W       = 2 * FRAC_BITS + 2;
  localparam int PAY_W       = FRAC_BITS + 2;
  localparam int CFG_W       = 17;
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_BIAS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DOM_LO  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DOM_LEN = 3'd3;
  localparam logic [IDX_W-1:0] REG_RNG_LO  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RNG_LEN = 3'd5;

  localparam logic [QUO_BITS-1:0] ONE_Q = QUO_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DIV_W-1:0]    rem;
    logic [DIV_W-1:0]    den;
    logic [QUO_BITS-1:0] quo;
    logic                sat;
    logic [PAY_W-1:0]    pay;
  } div_stage_t;

  // q1.14 setting to q0.16 fraction in (0,1)
  function automatic logic [FRAC_BITS-1:0] setting_to_frac(input logic signed [15:0] s);
    logic signed [15:0] c;
    logic [15:0]        p;
    logic [30:0]        prod;
    begin
      c = s;
      if (s < -16'sd16384) c = -16'sd16384;
      if (s > 16'sd16384) c = 16'sd16384;
      p = 16'(c + 16'sd16384);
      prod = 31'(p) * 31'd32767;
      setting_to_frac = FRAC_BITS'((prod >> 14) + 31'd1);
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/bgc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_div
// Pipelined restoring divider, floor(num * 2^17 / den) for num <= den,
// one quotient bit per stage, with a sideband payload.
// ----------------------------------------------------------------------------
module bgc_div import bgc_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire [DIV_W-1:0]     in_num,
  input  wire [DIV_W-1:0]     in_den,
  input  wire [PAY_W-1:0]     in_pay,
  output logic                out_valid,
  output logic [QUO_BITS:0]   out_quo,
  output logic [PAY_W-1:0]    out_pay
);

  div_stage_t st_r  [QUO_BITS+1];
  div_stage_t st_nxt[QUO_BITS+1];
  logic [QUO_BITS:0] vld_r;

  always_comb begin
    logic [DIV_W:0] dbl;
    st_nxt[0].rem = in_num;
    st_nxt[0].den = in_den;
    st_nxt[0].quo = '0;
    st_nxt[0].sat = (in_num >= in_den);
    st_nxt[0].pay = in_pay;
    for (int i = 1; i <= QUO_BITS; i++) begin
      st_nxt[i] = st_r[i-1];
      dbl = {st_r[i-1].rem, 1'b0};
      st_nxt[i].quo = {st_r[i-1].quo[QUO_BITS-2:0], 1'b0};
      if (dbl >= {1'b0, st_r[i-1].den}) begin
        st_nxt[i].rem    = DIV_W'(dbl - {1'b0, st_r[i-1].den});
        st_nxt[i].quo[0] = 1'b1;
      end else begin
        st_nxt[i].rem = DIV_W'(dbl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_BITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= QUO_BITS; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid = vld_r[QUO_BITS];
  assign out_quo   = st_r[QUO_BITS].sat ? {1'b1, {QUO_BITS{1'b0}}}
                                        : {1'b0, st_r[QUO_BITS].quo};
  assign out_pay   = st_r[QUO_BITS].pay;

endmodule
`default_nettype wire

>>> hdl/bias_gain_curve_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bias_gain_curve_mapper
// Clamps each sample to the domain, maps it through a bias then gain curve
// and scales it into the output range with saturation.
// ----------------------------------------------------------------------------
// One sample is taken every clock while the output is not stalled; the path
// runs through three 18-stage bit-per-stage dividers (domain scaling, bias,
// gain). The whole pipeline holds while a result waits on out_tready.
// Write configuration only while no transaction is in flight.
module bias_gain_curve_mapper import bgc_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [15:0]             in_tdata,   // sample_in
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [15:0]            out_tdata,  // sample_out
  input  wire                    cfg_we,
  input  wire [IDX_W-1:0]        cfg_addr,
  input  wire [CFG_W-1:0]        cfg_wdata
);

  logic [15:0] bias_r, gain_r, dom_lo_r, dom_len_r, rng_lo_r;
  logic [16:0] rng_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r    <= '0;
      gain_r    <= '0;
      dom_lo_r  <= '0;
      dom_len_r <= 16'hFFFF;
      rng_lo_r  <= '0;
      rng_len_r <= 17'd65535;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BIAS:    bias_r    <= cfg_wdata[15:0];
        REG_GAIN:    gain_r    <= cfg_wdata[15:0];
        REG_DOM_LO:  dom_lo_r  <= cfg_wdata[15:0];
        REG_DOM_LEN: dom_len_r <= cfg_wdata[15:0];
        REG_RNG_LO:  rng_lo_r  <= cfg_wdata[15:0];
        REG_RNG_LEN: rng_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // derived settings
  logic [FRAC_BITS-1:0] b_q_r, g_q_r;
  logic [16:0]          mag_r;
  logic                 neg_r, bypass_r;
  logic [15:0]          dom_len_eff;

  assign dom_len_eff = (dom_len_r == '0) ? 16'd1 : dom_len_r;

  always_ff @(posedge clk) begin
    b_q_r    <= setting_to_frac(bias_r);
    g_q_r    <= setting_to_frac(gain_r);
    neg_r    <= rng_len_r[16];
    mag_r    <= rng_len_r[16] ? 17'(-rng_len_r) : rng_len_r;
    bypass_r <= (bias_r == '0) && (gain_r == '0);
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // domain clamp
  logic [16:0] hi_lim;
  logic [15:0] s_cl, n_a;
  always_comb begin
    hi_lim = {1'b0, dom_lo_r} + {1'b0, dom_len_eff};
    s_cl   = in_tdata;
    if (in_tdata < dom_lo_r) s_cl = dom_lo_r;
    if ({1'b0, in_tdata} > hi_lim) s_cl = hi_lim[15:0];
    n_a = s_cl - dom_lo_r;
  end

  logic              a_vld;
  logic [QUO_BITS:0] a_quo;
  logic [PAY_W-1:0]  a_pay;

  bgc_div u_div_dom (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(in_tvalid && in_tready),
    .in_num(DIV_W'(n_a)), .in_den(DIV_W'(dom_len_eff)), .in_pay('0),
    .out_valid(a_vld), .out_quo(a_quo), .out_pay(a_pay)
  );

  // x and bias products
  logic              p2_vld_r;
  logic [QUO_BITS-1:0] p2_x_r;
  logic              p3_vld_r;
  logic [QUO_BITS-1:0] p3_x_r;
  logic [DIV_W-1:0]  p3_num_r, p3_prd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= a_vld;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_x_r   <= QUO_BITS'((a_quo + (QUO_BITS+1)'(1)) >> 1);
      p3_x_r   <= p2_x_r;
      p3_num_r <= DIV_W'(p2_x_r * {1'b0, b_q_r});
      p3_prd_r <= DIV_W'((ONE_Q - p2_x_r) * (ONE_Q - {1'b0, b_q_r}));
    end
  end

  logic              b_vld;
  logic [QUO_BITS:0] b_quo;
  logic [PAY_W-1:0]  b_pay;

  bgc_div u_div_bias (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(p3_vld_r),
    .in_num(p3_num_r), .in_den(DIV_W'(p3_prd_r + p3_num_r)),
    .in_pay(PAY_W'(p3_x_r)),
    .out_valid(b_vld), .out_quo(b_quo), .out_pay(b_pay)
  );

  // gain branch select and products
  logic [QUO_BITS-1:0] t_val, u_val;
  assign t_val = b_quo[QUO_BITS:1];
  assign u_val = (t_val < (ONE_Q >> 1)) ? QUO_BITS'({t_val, 1'b0})
                                        : QUO_BITS'(({ONE_Q, 1'b0}) - {t_val, 1'b0});

  logic              p4_vld_r, p4_hi_r;
  logic [QUO_BITS-1:0] p4_u_r, p4_x_r;
  logic              p5_vld_r;
  logic [PAY_W-1:0]  p5_pay_r;
  logic [DIV_W-1:0]  p5_num_r, p5_prd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p4_vld_r <= b_vld;
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_u_r   <= u_val;
      p4_hi_r  <= !(t_val < (ONE_Q >> 1));
      p4_x_r   <= b_pay[QUO_BITS-1:0];
      p5_pay_r <= {p4_hi_r, p4_x_r};
      p5_num_r <= DIV_W'(p4_u_r * {1'b0, g_q_r});
      p5_prd_r <= DIV_W'((ONE_Q - p4_u_r) * (ONE_Q - {1'b0, g_q_r}));
    end
  end

  logic              c_vld;
  logic [QUO_BITS:0] c_quo;
  logic [PAY_W-1:0]  c_pay;

  bgc_div u_div_gain (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(p5_vld_r),
    .in_num(p5_num_r), .in_den(DIV_W'(p5_prd_r + p5_num_r)),
    .in_pay(p5_pay_r),
    .out_valid(c_vld), .out_quo(c_quo), .out_pay(c_pay)
  );

  // curve value, range scaling, saturation
  logic [QUO_BITS-1:0] v_half;
  assign v_half = QUO_BITS'(c_quo >> 2);

  logic              p6_vld_r, p7_vld_r;
  logic [QUO_BITS-1:0] p6_y_r;
  logic [DIV_W:0]    p7_m_r;
  logic [18:0]       o_sum;
  logic [17:0]       m_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r   <= 1'b0;
      p7_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (adv) begin
      p6_vld_r   <= c_vld;
      p7_vld_r   <= p6_vld_r;
      out_tvalid <= p7_vld_r;
    end
  end

  assign m_val = 18'(p7_m_r >> FRAC_BITS);
  assign o_sum = neg_r ? 19'({3'b0, rng_lo_r} - {1'b0, m_val})
                       : 19'({3'b0, rng_lo_r} + {1'b0, m_val});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (bypass_r) p6_y_r <= c_pay[QUO_BITS-1:0];
      else if (c_pay[QUO_BITS]) p6_y_r <= ONE_Q - v_half;
      else p6_y_r <= v_half;
      p7_m_r <= (DIV_W+1)'(p6_y_r * mag_r) + (DIV_W+1)'(ONE_Q >> 1);
      if (o_sum[18]) out_tdata <= '0;
      else if (o_sum[17:16] != 2'b00) out_tdata <= 16'hFFFF;
      else out_tdata <= o_sum[15:0];
    end
  end

endmodule
`default_nettype wire

>>> hdl/bgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_checker
// Port-level checks for the bias/gain curve mapper.
// ----------------------------------------------------------------------------
module bgc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled transaction changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  a_no_input_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_tready |-> 1'b0)
    else $error("input blocked while output empty");

endmodule

bind bias_gain_curve_mapper bgc_checker u_bgc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
